// ===== design/nnu_pkg.sv =====
// ----------------------------------------------------------------------------
// Nearest-neighbor upsampler package
// Shared widths, register indexes, size clamps and the structs passed between
// the front end, the work queue and the copy generator.
// ----------------------------------------------------------------------------
package nnu_pkg;

   localparam int MAX_DIM      = 1024;
   localparam int MAX_CHANNELS = 1024;
   localparam int MAX_BATCH    = 16;
   localparam int MAX_STRIDE   = 8;

   localparam int SAMPLE_W = 16;
   localparam int GAIN_W   = 16;
   localparam int PROD_W   = SAMPLE_W + GAIN_W + 1;
   localparam int INDEX_W  = 40;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int DIM_W    = 11;
   localparam int BATCH_W  = 5;
   localparam int STRIDE_W = 4;
   localparam int COUNT_W  = 10;
   localparam int BIDX_W   = 4;
   localparam int SUB_W    = 3;
   localparam int LINE_W   = 14;
   localparam int ROWSTEP_W = 17;
   localparam int PLANE_W  = 27;
   localparam int COLBASE_W = 13;
   localparam int ROWBASE_W = 26;

   localparam logic [CSR_IDX_W-1:0] CSR_IN_WIDTH       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IN_HEIGHT      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BATCH_COUNT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UPSCALE_FACTOR = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN           = 3'd5;

   typedef struct packed {
      logic [STRIDE_W-1:0] stride;
      logic [LINE_W-1:0]   line_step;
   } geom_type;

   typedef struct packed {
      logic signed [PROD_W-1:0] prod;
      logic [INDEX_W-1:0]       start_index;
      logic                     last_sample;
   } entry_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [BATCH_W-1:0] clamp_batch(input logic [BATCH_W-1:0] v);
      logic [BATCH_W-1:0] r;
      if (v == '0) begin
         r = BATCH_W'(1);
      end else if (v > BATCH_W'(MAX_BATCH)) begin
         r = BATCH_W'(MAX_BATCH);
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [STRIDE_W-1:0] clamp_stride(input logic [STRIDE_W-1:0] v);
      logic [STRIDE_W-1:0] r;
      if (v == '0) begin
         r = STRIDE_W'(1);
      end else if (v > STRIDE_W'(MAX_STRIDE)) begin
         r = STRIDE_W'(MAX_STRIDE);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// ===== design/nnu_front.sv =====
// ----------------------------------------------------------------------------
// Nearest-neighbor upsampler front end
// Holds the configuration, tracks the raster position of the next sample,
// scales the sample and forms the index of its first copy.
// ----------------------------------------------------------------------------
module nnu_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [nnu_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [nnu_pkg::CSR_DATA_W-1:0]        csr_write_data,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [nnu_pkg::SAMPLE_W-1:0]   req_sample,
   output logic                                  push_valid,
   input  logic                                  push_ready,
   output nnu_pkg::entry_type                    push_entry,
   output nnu_pkg::geom_type                     geom
);

   logic [nnu_pkg::DIM_W-1:0]      width_ff, height_ff, chans_ff;
   logic [nnu_pkg::BATCH_W-1:0]    batches_ff;
   logic [nnu_pkg::STRIDE_W-1:0]   stride_ff;
   logic [nnu_pkg::GAIN_W-1:0]     gain_ff;
   logic [nnu_pkg::LINE_W-1:0]     line_step_ff;
   logic [nnu_pkg::ROWSTEP_W-1:0]  row_step_ff;
   logic [nnu_pkg::PLANE_W-1:0]    plane_ff;
   logic [1:0]                     settle_ff;

   logic [nnu_pkg::COUNT_W-1:0]    col_ff, row_ff, chan_ff;
   logic [nnu_pkg::BIDX_W-1:0]     batch_ff;
   logic [nnu_pkg::COLBASE_W-1:0]  col_base_ff;
   logic [nnu_pkg::ROWBASE_W-1:0]  row_base_ff;
   logic [nnu_pkg::INDEX_W-1:0]    plane_base_ff;

   logic                           out_valid_ff;
   nnu_pkg::entry_type             out_entry_ff;

   logic                           accept;
   logic                           col_last, row_last, chan_last, batch_last;
   logic                           csr_hit;
   logic signed [nnu_pkg::GAIN_W:0] gain_s;
   nnu_pkg::entry_type             entry_in;

   assign csr_hit = csr_write_enable && (csr_index <= nnu_pkg::CSR_GAIN);
   assign req_ready = (settle_ff == 2'd0) && (!out_valid_ff || push_ready);
   assign accept = req_valid && req_ready;

   assign col_last   = ({1'b0, col_ff} == width_ff - 1'b1);
   assign row_last   = ({1'b0, row_ff} == height_ff - 1'b1);
   assign chan_last  = ({1'b0, chan_ff} == chans_ff - 1'b1);
   assign batch_last = ({1'b0, batch_ff} == batches_ff - 1'b1);

   assign gain_s = $signed({1'b0, gain_ff});

   always_comb begin
      entry_in.prod = req_sample * gain_s;
      entry_in.start_index = plane_base_ff
                           + nnu_pkg::INDEX_W'(row_base_ff)
                           + nnu_pkg::INDEX_W'(col_base_ff);
      entry_in.last_sample = col_last && row_last && chan_last && batch_last;
   end

   always_ff @(posedge clock) begin
      line_step_ff <= nnu_pkg::LINE_W'(width_ff * stride_ff);
      row_step_ff  <= nnu_pkg::ROWSTEP_W'(line_step_ff * stride_ff);
      plane_ff     <= nnu_pkg::PLANE_W'(row_step_ff * height_ff);
      if (accept) begin
         out_entry_ff <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= nnu_pkg::DIM_W'(1);
         height_ff     <= nnu_pkg::DIM_W'(1);
         chans_ff      <= nnu_pkg::DIM_W'(1);
         batches_ff    <= nnu_pkg::BATCH_W'(1);
         stride_ff     <= nnu_pkg::STRIDE_W'(2);
         gain_ff       <= nnu_pkg::GAIN_W'(256);
         settle_ff     <= 2'd3;
         col_ff        <= '0;
         row_ff        <= '0;
         chan_ff       <= '0;
         batch_ff      <= '0;
         col_base_ff   <= '0;
         row_base_ff   <= '0;
         plane_base_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_hit) begin
            unique case (csr_index)
               nnu_pkg::CSR_IN_WIDTH: begin
                  width_ff <= nnu_pkg::clamp_dim(csr_write_data[nnu_pkg::DIM_W-1:0]);
               end
               nnu_pkg::CSR_IN_HEIGHT: begin
                  height_ff <= nnu_pkg::clamp_dim(csr_write_data[nnu_pkg::DIM_W-1:0]);
               end
               nnu_pkg::CSR_CHANNEL_COUNT: begin
                  chans_ff <= nnu_pkg::clamp_dim(csr_write_data[nnu_pkg::DIM_W-1:0]);
               end
               nnu_pkg::CSR_BATCH_COUNT: begin
                  batches_ff <= nnu_pkg::clamp_batch(csr_write_data[nnu_pkg::BATCH_W-1:0]);
               end
               nnu_pkg::CSR_UPSCALE_FACTOR: begin
                  stride_ff <= nnu_pkg::clamp_stride(csr_write_data[nnu_pkg::STRIDE_W-1:0]);
               end
               default: begin
                  gain_ff <= csr_write_data;
               end
            endcase
            settle_ff     <= 2'd3;
            col_ff        <= '0;
            row_ff        <= '0;
            chan_ff       <= '0;
            batch_ff      <= '0;
            col_base_ff   <= '0;
            row_base_ff   <= '0;
            plane_base_ff <= '0;
         end else begin
            if (settle_ff != 2'd0) begin
               settle_ff <= settle_ff - 2'd1;
            end
            if (accept) begin
               if (!col_last) begin
                  col_ff      <= col_ff + 1'b1;
                  col_base_ff <= col_base_ff + nnu_pkg::COLBASE_W'(stride_ff);
               end else begin
                  col_ff      <= '0;
                  col_base_ff <= '0;
                  if (!row_last) begin
                     row_ff      <= row_ff + 1'b1;
                     row_base_ff <= row_base_ff + nnu_pkg::ROWBASE_W'(row_step_ff);
                  end else begin
                     row_ff      <= '0;
                     row_base_ff <= '0;
                     if (!chan_last) begin
                        chan_ff       <= chan_ff + 1'b1;
                        plane_base_ff <= plane_base_ff + nnu_pkg::INDEX_W'(plane_ff);
                     end else begin
                        chan_ff <= '0;
                        if (!batch_last) begin
                           batch_ff      <= batch_ff + 1'b1;
                           plane_base_ff <= plane_base_ff + nnu_pkg::INDEX_W'(plane_ff);
                        end else begin
                           batch_ff      <= '0;
                           plane_base_ff <= '0;
                        end
                     end
                  end
               end
            end
         end
         if (accept) begin
            out_valid_ff <= 1'b1;
         end else if (push_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign push_valid     = out_valid_ff;
   assign push_entry     = out_entry_ff;
   assign geom.stride    = stride_ff;
   assign geom.line_step = line_step_ff;

endmodule

// ===== design/nnu_queue.sv =====
// ----------------------------------------------------------------------------
// Nearest-neighbor upsampler work queue
// Two-entry first-in first-out buffer between the front end and the copy
// generator, so that either side can stall without holding up the other.
// ----------------------------------------------------------------------------
module nnu_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_valid,
   output logic                wr_ready,
   input  nnu_pkg::entry_type  wr_entry,
   output logic                rd_valid,
   input  logic                rd_ready,
   output nnu_pkg::entry_type  rd_entry
);

   nnu_pkg::entry_type slots_ff [2];
   logic               wr_ptr_ff, rd_ptr_ff;
   logic [1:0]         count_ff;
   logic               push, pop;

   assign wr_ready = (count_ff != 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;
   assign rd_entry = slots_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

// ===== design/nnu_back.sv =====
// ----------------------------------------------------------------------------
// Nearest-neighbor upsampler copy generator
// Takes one queued sample at a time, saturates its scaled value and walks the
// stride by stride output block, presenting one copy per word.
// ----------------------------------------------------------------------------
module nnu_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  nnu_pkg::geom_type                     geom,
   input  logic                                  pop_valid,
   output logic                                  pop_ready,
   input  nnu_pkg::entry_type                    pop_entry,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [nnu_pkg::INDEX_W-1:0]           rsp_out_index,
   output logic signed [nnu_pkg::SAMPLE_W-1:0]   rsp_value,
   output logic                                  rsp_last_copy,
   output logic                                  rsp_tensor_done
);

   logic                                valid_ff;
   logic [nnu_pkg::INDEX_W-1:0]         index_ff, line_ff;
   logic signed [nnu_pkg::SAMPLE_W-1:0] value_ff;
   logic                                last_sample_ff;
   logic [nnu_pkg::SUB_W-1:0]           dx_ff, dy_ff;

   logic                                last_copy, row_end, load;
   logic signed [nnu_pkg::PROD_W-9:0]   shifted;
   logic signed [nnu_pkg::SAMPLE_W-1:0] value_in;
   logic [nnu_pkg::INDEX_W-1:0]         next_line;

   assign row_end   = ({1'b0, dx_ff} == geom.stride - 1'b1);
   assign last_copy = row_end && ({1'b0, dy_ff} == geom.stride - 1'b1);
   assign load      = pop_valid && (!valid_ff || (rsp_ready && last_copy));
   assign pop_ready = load;
   assign next_line = line_ff + nnu_pkg::INDEX_W'(geom.line_step);

   assign shifted = pop_entry.prod[nnu_pkg::PROD_W-1:8];

   always_comb begin
      if (!shifted[nnu_pkg::PROD_W-9] && (|shifted[nnu_pkg::PROD_W-10:nnu_pkg::SAMPLE_W-1])) begin
         value_in = {1'b0, {(nnu_pkg::SAMPLE_W-1){1'b1}}};
      end else if (shifted[nnu_pkg::PROD_W-9]
                   && !(&shifted[nnu_pkg::PROD_W-10:nnu_pkg::SAMPLE_W-1])) begin
         value_in = {1'b1, {(nnu_pkg::SAMPLE_W-1){1'b0}}};
      end else begin
         value_in = shifted[nnu_pkg::SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         index_ff       <= pop_entry.start_index;
         line_ff        <= pop_entry.start_index;
         value_ff       <= value_in;
         last_sample_ff <= pop_entry.last_sample;
      end else if (valid_ff && rsp_ready && !last_copy) begin
         if (!row_end) begin
            index_ff <= index_ff + 1'b1;
         end else begin
            index_ff <= next_line;
            line_ff  <= next_line;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         dx_ff    <= '0;
         dy_ff    <= '0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            dx_ff    <= '0;
            dy_ff    <= '0;
         end else if (valid_ff && rsp_ready) begin
            if (last_copy) begin
               valid_ff <= 1'b0;
            end else if (!row_end) begin
               dx_ff <= dx_ff + 1'b1;
            end else begin
               dx_ff <= '0;
               dy_ff <= dy_ff + 1'b1;
            end
         end
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_index   = index_ff;
   assign rsp_value       = value_ff;
   assign rsp_last_copy   = last_copy;
   assign rsp_tensor_done = last_copy && last_sample_ff;

endmodule

// ===== design/nearest_neighbor_upsampler.sv =====
// ----------------------------------------------------------------------------
// Nearest-neighbor upsampler
// Forward nearest-neighbor upsampling of a batched multi-channel tensor.
// ----------------------------------------------------------------------------
// Input samples arrive on the req channel in raster order: batch, channel,
// row, column. Each sample produces S*S words on the rsp channel, where S is
// the upscale factor, sub-row by sub-row and left to right within a sub-row.
// Each word carries the linear output index, the sample times gain in Q8.8
// with saturation, and flags for the last copy of the sample and of the tensor.
// An accepted sample passes the front-end output register and a queue slot
// before the copy generator loads it and shows its first copy. It emits one
// word per cycle while rsp_ready is high; a two-entry queue lets the front
// end take new samples while copies drain. When the receiver stalls, the
// current word holds and the queue fills, after which req_ready drops. A csr
// write to index 0 to 5 takes effect on any cycle and rewinds the raster
// position; indexes 6 and 7 are ignored. After such a write, and after reset,
// req_ready stays low while the line step, row step and plane size are
// recomputed. Reset restores the default sizes, factor two and unity gain.
// ----------------------------------------------------------------------------
module nearest_neighbor_upsampler (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [nnu_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [nnu_pkg::CSR_DATA_W-1:0]        csr_write_data,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [nnu_pkg::SAMPLE_W-1:0]   req_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [nnu_pkg::INDEX_W-1:0]           rsp_out_index,
   output logic signed [nnu_pkg::SAMPLE_W-1:0]   rsp_value,
   output logic                                  rsp_last_copy,
   output logic                                  rsp_tensor_done
);

   nnu_pkg::geom_type  geom;
   nnu_pkg::entry_type push_entry, pop_entry;
   logic               push_valid, push_ready, pop_valid, pop_ready;

   nnu_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_entry       (push_entry),
      .geom             (geom)
   );

   nnu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (push_valid),
      .wr_ready (push_ready),
      .wr_entry (push_entry),
      .rd_valid (pop_valid),
      .rd_ready (pop_ready),
      .rd_entry (pop_entry)
   );

   nnu_back u_back (
      .clock           (clock),
      .reset           (reset),
      .geom            (geom),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_entry       (pop_entry),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_index   (rsp_out_index),
      .rsp_value       (rsp_value),
      .rsp_last_copy   (rsp_last_copy),
      .rsp_tensor_done (rsp_tensor_done)
   );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Nearest-neighbor upsampler testbench
// Feeds samples through the req channel and checks every copy on the rsp
// channel against an in-bench model of the raster walk, the output index
// formula and the saturating Q8.8 gain. A directed table comes first, then
// random phases that change the sizes, factor and gain between phases while
// the sender and receiver idle at different rates.
// ----------------------------------------------------------------------------
module tb_top;

   localparam logic [nnu_pkg::CSR_IDX_W-1:0] CSR_UNUSED_LO = 3'd6;
   localparam logic [nnu_pkg::CSR_IDX_W-1:0] CSR_UNUSED_HI = 3'd7;

   localparam int SETTLE_CYCLES = 6;
   localparam int TAIL_CYCLES   = 20;
   localparam int STALL_LIMIT   = 2000;
   localparam int MAX_REPORTS   = 30;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS   = 36;
   localparam int DRILL_ROWS    = 46;

   typedef enum logic {ROW_CSR, ROW_SAMPLE} row_kind_type;

   typedef struct packed {
      row_kind_type                         kind;
      logic [nnu_pkg::CSR_IDX_W-1:0]        reg_index;
      logic [nnu_pkg::CSR_DATA_W-1:0]       reg_data;
      logic signed [nnu_pkg::SAMPLE_W-1:0]  sample;
      logic                                 typed;
      logic signed [nnu_pkg::SAMPLE_W-1:0]  typed_value;
   } drill_row_type;

   typedef struct packed {
      logic [nnu_pkg::INDEX_W-1:0]          out_index;
      logic signed [nnu_pkg::SAMPLE_W-1:0]  value;
      logic                                 last_copy;
      logic                                 tensor_done;
   } upsample_copy_type;

   logic                                 clock;
   logic                                 reset = 1'b1;
   logic                                 csr_write_enable = 1'b0;
   logic [nnu_pkg::CSR_IDX_W-1:0]        csr_index = '0;
   logic [nnu_pkg::CSR_DATA_W-1:0]       csr_write_data = '0;
   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   logic signed [nnu_pkg::SAMPLE_W-1:0]  req_sample = '0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   logic [nnu_pkg::INDEX_W-1:0]          rsp_out_index;
   logic signed [nnu_pkg::SAMPLE_W-1:0]  rsp_value;
   logic                                 rsp_last_copy;
   logic                                 rsp_tensor_done;

   logic [nnu_pkg::DIM_W-1:0]    cfg_width;
   logic [nnu_pkg::DIM_W-1:0]    cfg_height;
   logic [nnu_pkg::DIM_W-1:0]    cfg_channels;
   logic [nnu_pkg::BATCH_W-1:0]  cfg_batches;
   logic [nnu_pkg::STRIDE_W-1:0] cfg_stride;
   logic [nnu_pkg::GAIN_W-1:0]   cfg_gain;
   longint unsigned     col_pos, row_pos, chan_pos, batch_pos;

   upsample_copy_type copy_queue[$];
   int             mismatch_count = 0;
   int             send_idle_pct = 0;
   int             rsp_stall_pct = 0;
   logic           pin_value_en = 1'b0;
   logic signed [nnu_pkg::SAMPLE_W-1:0] pin_value = '0;

   drill_row_type drill [DRILL_ROWS] = '{
      '{ROW_SAMPLE, nnu_pkg::CSR_IN_WIDTH, 16'h0000, 16'sh7FFF, 1'b1, 16'sh7FFF},
      '{ROW_SAMPLE, nnu_pkg::CSR_IN_WIDTH, 16'h0000, 16'sh8000, 1'b1, 16'sh8000},
      '{ROW_SAMPLE, nnu_pkg::CSR_IN_WIDTH, 16'h0000, 16'sh0000, 1'b1, 16'sh0000},
      '{ROW_SAMPLE, nnu_pkg::CSR_IN_WIDTH, 16'h0000, 16'shFFFF, 1'b1, 16'shFFFF},
      '{ROW_CSR, nnu_pkg::CSR_GAIN, 16'hFFFF, 16'sh0000, 1'b0, 16'sh0000},
      '{ROW_SAMPLE, nnu_pkg::CSR_IN_WIDTH, 16'h0000, 16'sh7FFF, 1'b1, 16'sh7FFF},
      '{ROW_SAMPLE, nnu_pkg::CSR_IN_WIDTH, 16'h0000, 16'sh8000, 1'b1, 16'sh8000},
      '{ROW_SAMPLE, nnu_pkg::CSR_IN_WIDTH, 16'h0000, 16'sh0001, 1'b1, 16'sh00FF},
      '{ROW_SAMPLE, nnu_pkg::CSR_IN_WIDTH, 16'h0000, 16'shFFFF, 1'b1, 16'shFF00},
      '{ROW_CSR, nnu_pkg::CSR_GAIN, 16'h0000, 16'sh0000, 1'b0, 16'sh0000},
      '{ROW_SAMPLE, nnu_pkg::CSR_IN_WIDTH, 16'h0000, 16'sh7FFF, 1'b1, 16'sh0000},
      '{ROW_SAMPLE, nnu_pkg::CSR_IN_WIDTH, 16'h0000, 16'sh8000, 1'b1, 16'sh0000},
      '{ROW_CSR, nnu_pkg::CSR_GAIN, 16'h0180, 16'sh0000, 1'b0, 16'sh0000},
      '{ROW_SAMPLE, nnu_pkg::CSR_IN_WIDTH, 16'h0000, 16'sh5555, 1'b0, 16'sh0000},
      '{ROW_SAMPLE, nnu_pkg::CSR_IN_WIDTH, 16'h0000, 16'shAAAA, 1'b0, 16'sh0000},
      '{ROW_CSR, nnu_pkg::CSR_IN_WIDTH, 16'hFFFF, 16'sh0000, 1'b0, 16'sh0000},
      '{ROW_CSR, nnu_pkg::CSR_IN_HEIGHT, 16'h0000, 16'sh0000, 1'b0, 16'sh0000},
      '{ROW_CSR, nnu_pkg::CSR_CHANNEL_COUNT, 16'h07FF, 16'sh0000, 1'b0, 16'sh0000},
      '{ROW_CSR, nnu_pkg::CSR_BATCH_COUNT, 16'h001F, 16'sh0000, 1'b0, 16'sh0000},
      '{ROW_CSR, nnu_pkg::CSR_UPSCALE_FACTOR, 16'h000F, 16'sh0000, 1'b0, 16'sh0000},
      '{ROW_CSR, nnu_pkg::CSR_GAIN, 16'h0100, 16'sh0000, 1'b0, 16'sh0000},
      '{ROW_SAMPLE, nnu_pkg::CSR_IN_WIDTH, 16'h0000, 16'sh1234, 1'b0, 16'sh0000},
      '{ROW_SAMPLE, nnu_pkg::CSR_IN_WIDTH, 16'h0000, 16'sh8001, 1'b0, 16'sh0000},
      '{ROW_CSR, nnu_pkg::CSR_IN_WIDTH, 16'h0003, 16'sh0000, 1'b0, 16'sh0000},
      '{ROW_CSR, nnu_pkg::CSR_IN_HEIGHT, 16'h0001, 16'sh0000, 1'b0, 16'sh0000},
      '{ROW_CSR, nnu_pkg::CSR_CHANNEL_COUNT, 16'h0001, 16'sh0000, 1'b0, 16'sh0000},
      '{ROW_CSR, nnu_pkg::CSR_BATCH_COUNT, 16'h0001, 16'sh0000, 1'b0, 16'sh0000},
      '{ROW_CSR, nnu_pkg::CSR_UPSCALE_FACTOR, 16'h0000, 16'sh0000, 1'b0, 16'sh0000},
      '{ROW_SAMPLE, nnu_pkg::CSR_IN_WIDTH, 16'h0000, 16'sh0100, 1'b1, 16'sh0100},
      '{ROW_CSR, CSR_UNUSED_HI, 16'hFFFF, 16'sh0000, 1'b0, 16'sh0000},
      '{ROW_SAMPLE, nnu_pkg::CSR_IN_WIDTH, 16'h0000, 16'sh0200, 1'b1, 16'sh0200},
      '{ROW_CSR, CSR_UNUSED_LO, 16'h0000, 16'sh0000, 1'b0, 16'sh0000},
      '{ROW_SAMPLE, nnu_pkg::CSR_IN_WIDTH, 16'h0000, 16'sh0300, 1'b1, 16'sh0300},
      '{ROW_CSR, nnu_pkg::CSR_IN_WIDTH, 16'h0001, 16'sh0000, 1'b0, 16'sh0000},
      '{ROW_CSR, nnu_pkg::CSR_IN_HEIGHT, 16'h0002, 16'sh0000, 1'b0, 16'sh0000},
      '{ROW_CSR, nnu_pkg::CSR_CHANNEL_COUNT, 16'h0002, 16'sh0000, 1'b0, 16'sh0000},
      '{ROW_CSR, nnu_pkg::CSR_BATCH_COUNT, 16'h0002, 16'sh0000, 1'b0, 16'sh0000},
      '{ROW_CSR, nnu_pkg::CSR_UPSCALE_FACTOR, 16'h0002, 16'sh0000, 1'b0, 16'sh0000},
      '{ROW_SAMPLE, nnu_pkg::CSR_IN_WIDTH, 16'h0000, 16'sh0080, 1'b0, 16'sh0000},
      '{ROW_SAMPLE, nnu_pkg::CSR_IN_WIDTH, 16'h0000, 16'shFF80, 1'b0, 16'sh0000},
      '{ROW_SAMPLE, nnu_pkg::CSR_IN_WIDTH, 16'h0000, 16'sh4000, 1'b0, 16'sh0000},
      '{ROW_SAMPLE, nnu_pkg::CSR_IN_WIDTH, 16'h0000, 16'shC000, 1'b0, 16'sh0000},
      '{ROW_SAMPLE, nnu_pkg::CSR_IN_WIDTH, 16'h0000, 16'sh7F00, 1'b0, 16'sh0000},
      '{ROW_SAMPLE, nnu_pkg::CSR_IN_WIDTH, 16'h0000, 16'sh8100, 1'b0, 16'sh0000},
      '{ROW_SAMPLE, nnu_pkg::CSR_IN_WIDTH, 16'h0000, 16'sh00FF, 1'b0, 16'sh0000},
      '{ROW_SAMPLE, nnu_pkg::CSR_IN_WIDTH, 16'h0000, 16'shFF01, 1'b0, 16'sh0000}
   };

   nearest_neighbor_upsampler dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_index    (rsp_out_index),
      .rsp_value        (rsp_value),
      .rsp_last_copy    (rsp_last_copy),
      .rsp_tensor_done  (rsp_tensor_done)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned bound_size(input longint unsigned v,
                                                  input longint unsigned maxv);
      longint unsigned r;
      if (v == 0) begin
         r = 1;
      end else if (v > maxv) begin
         r = maxv;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [nnu_pkg::CSR_DATA_W-1:0] pick_dim(input int unsigned small_max,
                                                               input int unsigned maxv);
      int unsigned roll;
      logic [nnu_pkg::CSR_DATA_W-1:0] r;
      roll = $urandom_range(99);
      if (roll < 80) begin
         r = nnu_pkg::CSR_DATA_W'($urandom_range(small_max, 1));
      end else if (roll < 86) begin
         r = '0;
      end else if (roll < 92) begin
         r = nnu_pkg::CSR_DATA_W'(maxv);
      end else begin
         r = nnu_pkg::CSR_DATA_W'($urandom);
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("%0t mismatch in %s: got %0h, expected %0h", $time, what, got, want);
      end
   endtask

   // Queues the S*S copies of one sample and steps the raster position.
   task automatic expand_sample(input logic signed [nnu_pkg::SAMPLE_W-1:0] smp);
      longint unsigned w, h, c, nb, st, base, idx, dy, dx;
      longint          prod, scaled;
      logic signed [nnu_pkg::SAMPLE_W-1:0] v;
      logic            tensor_end;
      upsample_copy_type cp;
      w  = bound_size(64'(cfg_width), nnu_pkg::MAX_DIM);
      h  = bound_size(64'(cfg_height), nnu_pkg::MAX_DIM);
      c  = bound_size(64'(cfg_channels), nnu_pkg::MAX_CHANNELS);
      nb = bound_size(64'(cfg_batches), nnu_pkg::MAX_BATCH);
      st = bound_size(64'(cfg_stride), nnu_pkg::MAX_STRIDE);
      prod = longint'(smp) * longint'({1'b0, cfg_gain});
      scaled = prod >>> 8;
      if (scaled > 32767) begin
         scaled = 32767;
      end else if (scaled < -32768) begin
         scaled = -32768;
      end
      v = scaled[nnu_pkg::SAMPLE_W-1:0];
      if (pin_value_en) begin
         v = pin_value;
      end
      tensor_end = (col_pos + 1 >= w) && (row_pos + 1 >= h) &&
                   (chan_pos + 1 >= c) && (batch_pos + 1 >= nb);
      base = batch_pos * w * h * c * st * st + chan_pos * w * h * st * st;
      for (dy = 0; dy < st; dy++) begin
         for (dx = 0; dx < st; dx++) begin
            idx = base + (row_pos * st + dy) * w * st + (col_pos * st + dx);
            cp.out_index   = idx[nnu_pkg::INDEX_W-1:0];
            cp.value       = v;
            cp.last_copy   = (dy + 1 == st) && (dx + 1 == st);
            cp.tensor_done = cp.last_copy && tensor_end;
            copy_queue.push_back(cp);
         end
      end
      if (col_pos + 1 < w) begin
         col_pos++;
      end else begin
         col_pos = 0;
         if (row_pos + 1 < h) begin
            row_pos++;
         end else begin
            row_pos = 0;
            if (chan_pos + 1 < c) begin
               chan_pos++;
            end else begin
               chan_pos = 0;
               batch_pos = (batch_pos + 1 < nb) ? batch_pos + 1 : 0;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      upsample_copy_type want;
      if (reset) begin
         cfg_width    = nnu_pkg::DIM_W'(1);
         cfg_height   = nnu_pkg::DIM_W'(1);
         cfg_channels = nnu_pkg::DIM_W'(1);
         cfg_batches  = nnu_pkg::BATCH_W'(1);
         cfg_stride   = nnu_pkg::STRIDE_W'(2);
         cfg_gain     = nnu_pkg::GAIN_W'(256);
         col_pos = 0;
         row_pos = 0;
         chan_pos = 0;
         batch_pos = 0;
         copy_queue.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               nnu_pkg::CSR_IN_WIDTH:
                  cfg_width    = csr_write_data[nnu_pkg::DIM_W-1:0];
               nnu_pkg::CSR_IN_HEIGHT:
                  cfg_height   = csr_write_data[nnu_pkg::DIM_W-1:0];
               nnu_pkg::CSR_CHANNEL_COUNT:
                  cfg_channels = csr_write_data[nnu_pkg::DIM_W-1:0];
               nnu_pkg::CSR_BATCH_COUNT:
                  cfg_batches  = csr_write_data[nnu_pkg::BATCH_W-1:0];
               nnu_pkg::CSR_UPSCALE_FACTOR:
                  cfg_stride   = csr_write_data[nnu_pkg::STRIDE_W-1:0];
               nnu_pkg::CSR_GAIN:
                  cfg_gain     = csr_write_data[nnu_pkg::GAIN_W-1:0];
               default: ;
            endcase
            if (csr_index <= nnu_pkg::CSR_GAIN) begin
               col_pos = 0;
               row_pos = 0;
               chan_pos = 0;
               batch_pos = 0;
            end
         end
         if (req_valid && req_ready) begin
            expand_sample(req_sample);
         end
         if (rsp_valid && rsp_ready) begin
            if (copy_queue.size() == 0) begin
               report_mismatch("word with nothing outstanding", 64'(rsp_out_index), '0);
            end else begin
               want = copy_queue.pop_front();
               if (rsp_out_index !== want.out_index) begin
                  report_mismatch("out_index", 64'(rsp_out_index), 64'(want.out_index));
               end
               if (rsp_value !== want.value) begin
                  report_mismatch("value", 64'(rsp_value), 64'(want.value));
               end
               if (rsp_last_copy !== want.last_copy) begin
                  report_mismatch("last_copy", 64'(rsp_last_copy), 64'(want.last_copy));
               end
               if (rsp_tensor_done !== want.tensor_done) begin
                  report_mismatch("tensor_done", 64'(rsp_tensor_done),
                                  64'(want.tensor_done));
               end
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic push_sample(input logic signed [nnu_pkg::SAMPLE_W-1:0] smp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= smp;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [nnu_pkg::CSR_IDX_W-1:0] idx,
                            input logic [nnu_pkg::CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (copy_queue.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      int phase;
      int n;
      int unsigned roll;
      logic [nnu_pkg::CSR_DATA_W-1:0] data;
      logic signed [nnu_pkg::SAMPLE_W-1:0] smp;

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int r = 0; r < DRILL_ROWS; r++) begin
         if (drill[r].kind == ROW_CSR) begin
            if (!csr_write_enable) begin
               settle();
            end
            write_reg(drill[r].reg_index, drill[r].reg_data);
         end else begin
            if (csr_write_enable) begin
               csr_write_enable <= 1'b0;
            end
            pin_value_en = drill[r].typed;
            pin_value    = drill[r].typed_value;
            push_sample(drill[r].sample);
         end
      end

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         pin_value_en = 1'b0;
         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 45;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 45;
            end
            default: begin
               send_idle_pct = 17;
               rsp_stall_pct = 17;
            end
         endcase
         if (phase == 0 || $urandom_range(1) != 0) begin
            write_reg(nnu_pkg::CSR_IN_WIDTH, pick_dim(4, nnu_pkg::MAX_DIM));
         end
         if (phase == 0 || $urandom_range(1) != 0) begin
            write_reg(nnu_pkg::CSR_IN_HEIGHT, pick_dim(3, nnu_pkg::MAX_DIM));
         end
         if (phase == 0 || $urandom_range(1) != 0) begin
            write_reg(nnu_pkg::CSR_CHANNEL_COUNT, pick_dim(3, nnu_pkg::MAX_CHANNELS));
         end
         if (phase == 0 || $urandom_range(1) != 0) begin
            write_reg(nnu_pkg::CSR_BATCH_COUNT, pick_dim(2, nnu_pkg::MAX_BATCH));
         end
         if (phase == 0 || $urandom_range(1) != 0) begin
            roll = $urandom_range(99);
            if (roll < 75) begin
               data = nnu_pkg::CSR_DATA_W'($urandom_range(3, 1));
            end else if (roll < 88) begin
               data = nnu_pkg::CSR_DATA_W'(nnu_pkg::MAX_STRIDE);
            end else if (roll < 94) begin
               data = '0;
            end else begin
               data = nnu_pkg::CSR_DATA_W'($urandom);
            end
            write_reg(nnu_pkg::CSR_UPSCALE_FACTOR, data);
         end
         if (phase == 0 || $urandom_range(1) != 0) begin
            roll = $urandom_range(99);
            if (roll < 35) begin
               data = nnu_pkg::CSR_DATA_W'(256);
            end else if (roll < 45) begin
               data = '0;
            end else if (roll < 55) begin
               data = '1;
            end else begin
               data = nnu_pkg::CSR_DATA_W'($urandom);
            end
            write_reg(nnu_pkg::CSR_GAIN, data);
         end
         if ($urandom_range(3) == 0) begin
            write_reg(($urandom_range(1) != 0) ? CSR_UNUSED_LO : CSR_UNUSED_HI,
                      nnu_pkg::CSR_DATA_W'($urandom));
         end
         if (csr_write_enable) begin
            csr_write_enable <= 1'b0;
         end
         for (n = 0; n < PHASE_ITEMS; n++) begin
            case ($urandom_range(9))
               0: smp = 16'sh7FFF;
               1: smp = 16'sh8000;
               2: smp = ($urandom_range(1) != 0) ? 16'sh0001 : 16'shFFFF;
               default: smp = nnu_pkg::SAMPLE_W'($urandom);
            endcase
            push_sample(smp);
         end
      end

      req_valid <= 1'b0;
      while (copy_queue.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && copy_queue.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
